// File: src/multi_deque_manager_assert.svh
// assertion macros for the multi deque manager
// expects clk_i and rst_ni in the scope of the module that uses them
`ifndef MULTI_DEQUE_MANAGER_ASSERT_SVH
`define MULTI_DEQUE_MANAGER_ASSERT_SVH

// same-cycle implication
`define MDQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MDQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/mdq_pkg.sv
// shared constants, payload structs and controller/datapath command types
// for the multi deque manager; no dependencies
package mdq_pkg;

  localparam int NumQueues  = 16;
  localparam int QueueDepth = 64;
  localparam int MemDepth   = NumQueues * QueueDepth;

  localparam int QIdxW = $clog2(NumQueues);
  localparam int PtrW  = $clog2(QueueDepth);
  localparam int CntW  = $clog2(QueueDepth + 1);
  localparam int SumW  = CntW + 1;
  localparam int AddrW = $clog2(MemDepth);

  localparam logic [1:0] ReqPush  = 2'd0;
  localparam logic [1:0] ReqPop   = 2'd1;
  localparam logic [1:0] ReqMerge = 2'd2;

  localparam logic [1:0] StatusOk    = 2'd0;
  localparam logic [1:0] StatusEmpty = 2'd1;
  localparam logic [1:0] StatusFull  = 2'd2;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [3:0]         queue_id;
    logic               end_sel;
    logic [3:0]         source_queue;
    logic               reverse_order;
    logic signed [31:0] push_value;
  } mdq_req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic               has_data;
    logic signed [31:0] pop_value;
  } mdq_rsp_t;

  typedef enum logic [1:0] {
    ResOk,
    ResFull,
    ResEmpty,
    ResPop
  } res_e;

  typedef struct packed {
    logic load_req;
    logic load_b;
    logic ptr_rd_src;
    logic push_do;
    logic pop_do;
    logic mv_rd;
    logic mv_wr;
    logic wb_b;
    logic wb_a;
    logic out_load;
    res_e out_kind;
  } mdq_cmd_t;

  typedef struct packed {
    logic [1:0] req_kind;
    logic       bad_q;
    logic       bad_src;
    logic       a_full;
    logic       a_empty;
    logic       b_empty;
    logic       same_q;
    logic       overflow;
    logic       out_free;
  } mdq_stat_t;

endpackage

// File: src/mdq_datapath.sv
// datapath: request register, pointer file, element store and result register
// depends on mdq_pkg and multi_deque_manager_assert.svh
`include "multi_deque_manager_assert.svh"

module mdq_datapath (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mdq_pkg::mdq_req_t  in_req_i,
  input  mdq_pkg::mdq_cmd_t  cmd_i,
  output mdq_pkg::mdq_stat_t stat_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output mdq_pkg::mdq_rsp_t  out_rsp_o
);
  import mdq_pkg::*;

  function automatic logic [PtrW-1:0] ptr_wrap(input logic [SumW-1:0] x);
    logic [SumW-1:0] y;
    y = (x >= SumW'(QueueDepth)) ? (x - SumW'(QueueDepth)) : x;
    return y[PtrW-1:0];
  endfunction

  function automatic logic [AddrW-1:0] slot_addr(input logic [QIdxW-1:0] q,
                                                 input logic [PtrW-1:0] off);
    return AddrW'(q) * AddrW'(QueueDepth) + AddrW'(off);
  endfunction

  mdq_req_t req_q;
  logic [PtrW-1:0] a_head_q, b_head_q;
  logic [CntW-1:0] a_cnt_q, b_cnt_q;
  logic [31:0] rdata_q;
  mdq_rsp_t out_q;
  logic out_valid_q;

  logic [PtrW-1:0] head_q [NumQueues];
  logic [CntW-1:0] cnt_q  [NumQueues];
  logic [31:0]     mem    [MemDepth];

  logic [QIdxW-1:0] rd_idx, q_idx, s_idx;
  logic [PtrW-1:0]  rd_head;
  logic [CntW-1:0]  rd_cnt;

  logic [PtrW-1:0] a_tail, a_last, a_prev, a_next, b_last, b_next;

  logic             ptr_we;
  logic [QIdxW-1:0] ptr_widx;
  logic [PtrW-1:0]  ptr_whead;
  logic [CntW-1:0]  ptr_wcnt;

  logic             mem_we, mem_re;
  logic [AddrW-1:0] mem_waddr, mem_raddr;
  logic [31:0]      mem_wdata;

  assign q_idx  = req_q.queue_id[QIdxW-1:0];
  assign s_idx  = req_q.source_queue[QIdxW-1:0];
  assign rd_idx = cmd_i.ptr_rd_src ? s_idx : in_req_i.queue_id[QIdxW-1:0];
  assign rd_head = head_q[rd_idx];
  assign rd_cnt  = cnt_q[rd_idx];

  assign a_tail = ptr_wrap(SumW'(a_head_q) + SumW'(a_cnt_q));
  assign a_last = ptr_wrap(SumW'(a_head_q) + SumW'(a_cnt_q) - SumW'(1));
  assign a_next = ptr_wrap(SumW'(a_head_q) + SumW'(1));
  assign a_prev = (a_head_q == '0) ? PtrW'(QueueDepth - 1) : (a_head_q - PtrW'(1));
  assign b_last = ptr_wrap(SumW'(b_head_q) + SumW'(b_cnt_q) - SumW'(1));
  assign b_next = ptr_wrap(SumW'(b_head_q) + SumW'(1));

  always_comb begin
    stat_o.req_kind = req_q.req_type;
    stat_o.bad_q    = int'(req_q.queue_id) >= NumQueues;
    stat_o.bad_src  = int'(req_q.source_queue) >= NumQueues;
    stat_o.a_full   = a_cnt_q >= CntW'(QueueDepth);
    stat_o.a_empty  = a_cnt_q == '0;
    stat_o.b_empty  = b_cnt_q == '0;
    stat_o.same_q   = req_q.queue_id == req_q.source_queue;
    stat_o.overflow = (SumW'(a_cnt_q) + SumW'(b_cnt_q)) > SumW'(QueueDepth);
    stat_o.out_free = !out_valid_q || out_ready_i;
  end

  // one pointer-file write and one store write / read per cycle
  always_comb begin
    ptr_we    = 1'b0;
    ptr_widx  = q_idx;
    ptr_whead = a_head_q;
    ptr_wcnt  = a_cnt_q;
    mem_we    = 1'b0;
    mem_waddr = slot_addr(q_idx, a_tail);
    mem_wdata = rdata_q;
    mem_re    = 1'b0;
    mem_raddr = slot_addr(q_idx, a_head_q);
    if (cmd_i.push_do) begin
      ptr_we    = 1'b1;
      ptr_whead = req_q.end_sel ? a_head_q : a_prev;
      ptr_wcnt  = a_cnt_q + CntW'(1);
      mem_we    = 1'b1;
      mem_waddr = slot_addr(q_idx, req_q.end_sel ? a_tail : a_prev);
      mem_wdata = req_q.push_value;
    end
    if (cmd_i.pop_do) begin
      ptr_we    = 1'b1;
      ptr_whead = req_q.end_sel ? a_head_q : a_next;
      ptr_wcnt  = a_cnt_q - CntW'(1);
      mem_re    = 1'b1;
      mem_raddr = slot_addr(q_idx, req_q.end_sel ? a_last : a_head_q);
    end
    if (cmd_i.mv_rd) begin
      mem_re    = 1'b1;
      mem_raddr = slot_addr(s_idx, req_q.reverse_order ? b_last : b_head_q);
    end
    if (cmd_i.mv_wr) begin
      mem_we = 1'b1;
    end
    if (cmd_i.wb_b) begin
      ptr_we    = 1'b1;
      ptr_widx  = s_idx;
      ptr_whead = b_head_q;
      ptr_wcnt  = b_cnt_q;
    end
    if (cmd_i.wb_a) begin
      ptr_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumQueues; i++) begin
        head_q[i] <= '0;
        cnt_q[i]  <= '0;
      end
    end else if (ptr_we) begin
      head_q[ptr_widx] <= ptr_whead;
      cnt_q[ptr_widx]  <= ptr_wcnt;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  // working copies of destination (a) and source (b) pointers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_q    <= in_req_i;
      a_head_q <= rd_head;
      a_cnt_q  <= rd_cnt;
    end else if (cmd_i.mv_wr) begin
      a_cnt_q <= a_cnt_q + CntW'(1);
    end
    if (cmd_i.load_b) begin
      b_head_q <= rd_head;
      b_cnt_q  <= rd_cnt;
    end else if (cmd_i.mv_rd) begin
      b_head_q <= req_q.reverse_order ? b_head_q : b_next;
      b_cnt_q  <= b_cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      case (cmd_i.out_kind)
        ResFull: begin
          out_q.status    <= StatusFull;
          out_q.has_data  <= 1'b0;
          out_q.pop_value <= '0;
        end
        ResEmpty: begin
          out_q.status    <= StatusEmpty;
          out_q.has_data  <= 1'b1;
          out_q.pop_value <= '1;
        end
        ResPop: begin
          out_q.status    <= StatusOk;
          out_q.has_data  <= 1'b1;
          out_q.pop_value <= rdata_q;
        end
        default: begin
          out_q.status    <= StatusOk;
          out_q.has_data  <= 1'b0;
          out_q.pop_value <= '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  `MDQ_ASSERT_IMP(a_cnt_bound, ptr_we, ptr_wcnt <= CntW'(QueueDepth), "queue count over depth")
  `MDQ_ASSERT_IMP(a_no_overwrite, cmd_i.out_load, !out_valid_q || out_ready_i, "result overwritten")
  `MDQ_ASSERT_IMP(a_move_nonempty, cmd_i.mv_rd, b_cnt_q != '0, "move from empty source")
  `MDQ_ASSERT_NXT(a_load_valid, cmd_i.out_load, out_valid_q, "loaded result not valid")

endmodule

// File: src/mdq_ctrl.sv
// controller state machine: sequences push, pop and merge requests
// depends on mdq_pkg
module mdq_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  mdq_pkg::mdq_stat_t stat_i,
  output mdq_pkg::mdq_cmd_t  cmd_o
);
  import mdq_pkg::*;

  typedef enum logic [3:0] {
    StIdle,
    StExec,
    StPopWait,
    StMergeChk,
    StMoveRd,
    StMoveWr,
    StWbSrc,
    StWbDst,
    StResp
  } state_e;

  state_e state_q, state_d;
  res_e   res_q, res_d;
  logic   fin;
  res_e   fin_res;

  always_comb begin
    cmd_o      = '0;
    state_d    = state_q;
    res_d      = res_q;
    in_ready_o = 1'b0;
    fin        = 1'b0;
    fin_res    = ResOk;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_req = 1'b1;
          state_d        = StExec;
        end
      end
      StExec: begin
        case (stat_i.req_kind)
          ReqPush: begin
            fin = 1'b1;
            if (stat_i.bad_q || stat_i.a_full) begin
              fin_res = ResFull;
            end else begin
              cmd_o.push_do = 1'b1;
            end
          end
          ReqPop: begin
            if (stat_i.bad_q || stat_i.a_empty) begin
              fin     = 1'b1;
              fin_res = ResEmpty;
            end else begin
              cmd_o.pop_do = 1'b1;
              state_d      = StPopWait;
            end
          end
          ReqMerge: begin
            if (stat_i.bad_q || stat_i.bad_src) begin
              fin     = 1'b1;
              fin_res = ResFull;
            end else if (stat_i.same_q) begin
              fin = 1'b1;
            end else begin
              cmd_o.ptr_rd_src = 1'b1;
              cmd_o.load_b     = 1'b1;
              state_d          = StMergeChk;
            end
          end
          default: fin = 1'b1;
        endcase
      end
      StPopWait: begin
        fin     = 1'b1;
        fin_res = ResPop;
      end
      StMergeChk: begin
        if (stat_i.overflow) begin
          fin     = 1'b1;
          fin_res = ResFull;
        end else begin
          state_d = StMoveRd;
        end
      end
      StMoveRd: begin
        if (stat_i.b_empty) begin
          state_d = StWbSrc;
        end else begin
          cmd_o.mv_rd = 1'b1;
          state_d     = StMoveWr;
        end
      end
      StMoveWr: begin
        cmd_o.mv_wr = 1'b1;
        state_d     = StMoveRd;
      end
      StWbSrc: begin
        cmd_o.wb_b = 1'b1;
        state_d    = StWbDst;
      end
      StWbDst: begin
        cmd_o.wb_a = 1'b1;
        fin        = 1'b1;
      end
      StResp: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_kind = res_q;
          state_d        = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase

    // hand the result over now, or park it until the output frees up
    if (fin) begin
      if (stat_i.out_free) begin
        cmd_o.out_load = 1'b1;
        cmd_o.out_kind = fin_res;
        state_d        = StIdle;
      end else begin
        res_d   = fin_res;
        state_d = StResp;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      res_q   <= ResOk;
    end else begin
      state_q <= state_d;
      res_q   <= res_d;
    end
  end

endmodule

// File: src/multi_deque_manager.sv
// top level of the multi deque manager: controller plus datapath
// depends on mdq_pkg, mdq_ctrl and mdq_datapath
//
// channel   direction  handshake                payload
// request   in         in_valid_i / in_ready_o  in_req_i  (mdq_req_t)
// result    out        out_valid_o / out_ready_i out_rsp_o (mdq_rsp_t)
//
// one request at a time; a pop waits for its store read in StPopWait, a merge
// checks overflow, then moves elements in StMoveRd / StMoveWr (moves share the store ports)
// reset empties every queue at once through per-queue count flip-flops
// a finished result sits in the output register; the next request is taken
// while it waits, and the block stalls only if a second result is ready first
module multi_deque_manager (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  mdq_pkg::mdq_req_t  in_req_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output mdq_pkg::mdq_rsp_t  out_rsp_o
);
  import mdq_pkg::*;

  mdq_cmd_t  cmd;
  mdq_stat_t stat;

  mdq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  mdq_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_req_i    (in_req_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

endmodule

// File: test/multi_deque_manager_tb.sv
// self-checking testbench for multi_deque_manager: random push, pop and merge traffic
// against a queue-based scoreboard with random stalls on both channels
// depends on mdq_pkg and multi_deque_manager
module multi_deque_manager_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mdq_pkg::*;

  localparam logic [1:0] ReqUnused = 2'd3;
  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned HoldCycles = 400;

  class deque_scoreboard;
    logic signed [31:0] contents [NumQueues][$];
    mdq_rsp_t expected_rsps [$];
    int unsigned errors;

    function void add_back(int unsigned q, logic signed [31:0] v);
      contents[q].insert(contents[q].size(), v);
    endfunction

    function void add_front(int unsigned q, logic signed [31:0] v);
      contents[q].insert(0, v);
    endfunction

    function logic signed [31:0] take_front(int unsigned q);
      logic signed [31:0] v;
      v = contents[q][0];
      contents[q].delete(0);
      return v;
    endfunction

    function logic signed [31:0] take_back(int unsigned q);
      logic signed [31:0] v;
      v = contents[q][contents[q].size() - 1];
      contents[q].delete(contents[q].size() - 1);
      return v;
    endfunction

    function void note_request(mdq_req_t r);
      mdq_rsp_t e;
      logic signed [31:0] v;
      int unsigned d;
      int unsigned s;
      e = '0;
      d = r.queue_id;
      s = r.source_queue;
      case (r.req_type)
        ReqPush: begin
          if (d >= NumQueues || contents[d].size() >= QueueDepth) begin
            e.status = StatusFull;
          end else if (r.end_sel) begin
            add_back(d, r.push_value);
          end else begin
            add_front(d, r.push_value);
          end
        end
        ReqPop: begin
          e.has_data = 1'b1;
          if (d >= NumQueues || contents[d].size() == 0) begin
            e.status    = StatusEmpty;
            e.pop_value = -32'sd1;
          end else if (r.end_sel) begin
            e.pop_value = take_back(d);
          end else begin
            e.pop_value = take_front(d);
          end
        end
        ReqMerge: begin
          if (d >= NumQueues || s >= NumQueues) begin
            e.status = StatusFull;
          end else if (d != s) begin
            if (contents[d].size() + contents[s].size() > QueueDepth) begin
              e.status = StatusFull;
            end else begin
              while (contents[s].size() != 0) begin
                v = r.reverse_order ? take_back(s) : take_front(s);
                add_back(d, v);
              end
            end
          end
        end
        default: begin
        end
      endcase
      expected_rsps.insert(expected_rsps.size(), e);
    endfunction

    function void check_result(mdq_rsp_t got);
      mdq_rsp_t e;
      if (expected_rsps.size() == 0) begin
        $error("result item with no request outstanding: %p", got);
        errors++;
        return;
      end
      e = expected_rsps[0];
      expected_rsps.delete(0);
      if (got.status !== e.status) begin
        $error("status: expected %0d, actual %0d", e.status, got.status);
        errors++;
      end
      if (got.has_data !== e.has_data) begin
        $error("has_data: expected %0d, actual %0d", e.has_data, got.has_data);
        errors++;
      end
      if (got.pop_value !== e.pop_value) begin
        $error("pop_value: expected %0d, actual %0d", e.pop_value, got.pop_value);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_rsps.size();
    endfunction
  endclass

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_ready_o;
  mdq_req_t in_req_i    = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  mdq_rsp_t out_rsp_o;

  deque_scoreboard sb = new();
  int unsigned accepted_cnt = 0;
  int unsigned cycle_cnt = 0;
  bit quiet = 1'b0;

  multi_deque_manager uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // results leave before any newer request can produce one, so check first
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) sb.check_result(out_rsp_o);
      if (in_valid_i && in_ready_o) begin
        sb.note_request(in_req_i);
        accepted_cnt <= accepted_cnt + 1;
      end
    end
  end

  // result side: random stall bursts plus one long hold-off to back up the block
  initial begin
    bit held;
    int unsigned gap;
    held = 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      @(posedge clk_i);
      if (!held && accepted_cnt >= 150) begin
        held = 1'b1;
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        gap = $urandom_range(1, 16);
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic send_req(input mdq_req_t r);
    int unsigned gap;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 16);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  function automatic mdq_req_t make_req(logic [1:0] kind, logic [3:0] q, logic at_back,
                                        logic [3:0] src, logic rev, logic signed [31:0] val);
    mdq_req_t r;
    r.req_type      = kind;
    r.queue_id      = q;
    r.end_sel       = at_back;
    r.source_queue  = src;
    r.reverse_order = rev;
    r.push_value    = val;
    return r;
  endfunction

  // most traffic lands on a few queues so they fill, drain and overflow
  function automatic logic [3:0] pick_queue();
    if ($urandom_range(0, 99) < 75) return 4'($urandom_range(0, 3));
    return 4'($urandom_range(0, NumQueues - 1));
  endfunction

  function automatic mdq_req_t random_req(int unsigned push_pct, int unsigned pop_pct,
                                          int unsigned merge_pct);
    mdq_req_t r;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < push_pct) r.req_type = ReqPush;
    else if (roll < push_pct + pop_pct) r.req_type = ReqPop;
    else if (roll < push_pct + pop_pct + merge_pct) r.req_type = ReqMerge;
    else r.req_type = ReqUnused;
    r.queue_id      = pick_queue();
    r.source_queue  = pick_queue();
    r.end_sel       = 1'($urandom_range(0, 1));
    r.reverse_order = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 7))
      0: r.push_value = 32'sh8000_0000;
      1: r.push_value = 32'sh7fff_ffff;
      2: r.push_value = -32'sd1;
      default: r.push_value = $urandom;
    endcase
    return r;
  endfunction

  task automatic run_phase(int unsigned n_items, int unsigned push_pct, int unsigned pop_pct,
                           int unsigned merge_pct, int unsigned quiet_tail);
    mdq_req_t r;
    int unsigned sent;
    sent = 0;
    while (sent < n_items) begin
      if (n_items - sent <= quiet_tail) quiet = 1'b1;
      r = random_req(push_pct, pop_pct, merge_pct);
      send_req(r);
      sent++;
    end
  endtask

  initial begin
    mdq_req_t directed [$];
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed = '{
      make_req(ReqPush, 4'd0, 1'b1, 4'd0, 1'b0, 32'sh7fff_ffff),
      make_req(ReqPush, 4'd0, 1'b0, 4'd0, 1'b0, 32'sh8000_0000),
      make_req(ReqPush, 4'd0, 1'b1, 4'd0, 1'b0, 32'sd0),
      make_req(ReqPush, 4'd0, 1'b0, 4'd0, 1'b0, -32'sd1),
      make_req(ReqPush, 4'd15, 1'b1, 4'd15, 1'b1, 32'sh5a5a_5a5a),
      make_req(ReqPop, 4'd0, 1'b0, 4'd0, 1'b0, 32'sd0),
      make_req(ReqPop, 4'd0, 1'b1, 4'd0, 1'b0, 32'sd0),
      // pops of an empty queue from either end
      make_req(ReqPop, 4'd14, 1'b0, 4'd0, 1'b0, 32'sd0),
      make_req(ReqPop, 4'd14, 1'b1, 4'd0, 1'b0, 32'sd0),
      make_req(ReqMerge, 4'd1, 1'b0, 4'd0, 1'b0, 32'sd0),
      make_req(ReqPush, 4'd1, 1'b1, 4'd0, 1'b0, 32'sd77),
      make_req(ReqMerge, 4'd2, 1'b0, 4'd1, 1'b1, 32'sd0),
      // merge with itself is a no-op
      make_req(ReqMerge, 4'd2, 1'b0, 4'd2, 1'b0, 32'sd0),
      // merge from an empty source
      make_req(ReqMerge, 4'd3, 1'b0, 4'd5, 1'b1, 32'sd0),
      make_req(ReqMerge, 4'd15, 1'b1, 4'd2, 1'b0, 32'sd0),
      make_req(ReqMerge, 4'd0, 1'b0, 4'd15, 1'b1, 32'sd0),
      make_req(ReqUnused, 4'd15, 1'b1, 4'd15, 1'b1, -32'sd1),
      make_req(ReqPop, 4'd0, 1'b1, 4'd0, 1'b0, 32'sd0),
      make_req(ReqPop, 4'd0, 1'b0, 4'd0, 1'b0, 32'sd0),
      make_req(ReqPop, 4'd0, 1'b0, 4'd0, 1'b0, 32'sd0),
      make_req(ReqPop, 4'd0, 1'b1, 4'd0, 1'b0, 32'sd0)
    };
    foreach (directed[i]) send_req(directed[i]);

    // fill, then mixed traffic, then drain with no idling at the end
    run_phase(350, 70, 15, 10, 0);
    run_phase(350, 40, 40, 15, 0);
    run_phase(330, 25, 60, 10, 150);
    in_valid_i <= 1'b0;
    @(posedge clk_i);

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
